@@ rtl/core/ybc_pkg.sv @@
// Shared types and constants for the YUYV to BGR converter.
package ybc_pkg;

    localparam int YBC_COEF_FRAC_BITS = 12;
    localparam int YBC_GAIN_W         = 14;
    localparam int YBC_BYTE_W         = 8;
    localparam int YBC_CFG_IDX_W      = 3;
    localparam int YBC_CFG_DATA_W     = 14;
    // chroma difference is one bit wider than a byte, signed
    localparam int YBC_DIFF_W         = YBC_BYTE_W + 1;
    // unsigned gain (zero-extended) times signed difference
    localparam int YBC_PROD_W         = YBC_GAIN_W + 1 + YBC_DIFF_W;

    localparam logic [YBC_CFG_IDX_W-1:0] CFG_V_TO_RED    = 3'd0;
    localparam logic [YBC_CFG_IDX_W-1:0] CFG_U_TO_GREEN  = 3'd1;
    localparam logic [YBC_CFG_IDX_W-1:0] CFG_V_TO_GREEN  = 3'd2;
    localparam logic [YBC_CFG_IDX_W-1:0] CFG_U_TO_BLUE   = 3'd3;
    localparam logic [YBC_CFG_IDX_W-1:0] CFG_CHROMA_OFFS = 3'd4;

    // reset gains: BT.709-like coefficients at 12 fraction bits
    localparam logic [YBC_GAIN_W-1:0] RST_V_TO_RED    = 14'd6431;
    localparam logic [YBC_GAIN_W-1:0] RST_U_TO_GREEN  = 14'd766;
    localparam logic [YBC_GAIN_W-1:0] RST_V_TO_GREEN  = 14'd1910;
    localparam logic [YBC_GAIN_W-1:0] RST_U_TO_BLUE   = 14'd7601;
    localparam logic [YBC_BYTE_W-1:0] RST_CHROMA_OFFS = 8'd127;

    typedef struct packed {
        logic [YBC_GAIN_W-1:0] v_to_red;
        logic [YBC_GAIN_W-1:0] u_to_green;
        logic [YBC_GAIN_W-1:0] v_to_green;
        logic [YBC_GAIN_W-1:0] u_to_blue;
        logic [YBC_BYTE_W-1:0] chroma_offset;
    } ybc_cfg_t;

    typedef struct packed {
        logic signed [YBC_PROD_W-1:0] v_red;
        logic signed [YBC_PROD_W-1:0] u_green;
        logic signed [YBC_PROD_W-1:0] v_green;
        logic signed [YBC_PROD_W-1:0] u_blue;
    } ybc_prod_t;

    typedef struct packed {
        logic [YBC_BYTE_W-1:0] blue;
        logic [YBC_BYTE_W-1:0] green;
        logic [YBC_BYTE_W-1:0] red;
    } ybc_pixel_t;

endpackage

@@ rtl/core/ybc_chroma.sv @@
// Shared chroma stage: offset removal and the four registered gain products.
module ybc_chroma
    import ybc_pkg::*;
(
    input  logic                  clk,
    input  logic                  load,
    input  ybc_cfg_t              cfg,
    input  logic [YBC_BYTE_W-1:0] chroma_blue,
    input  logic [YBC_BYTE_W-1:0] chroma_red,
    output ybc_prod_t             prod
);

    logic signed [YBC_DIFF_W-1:0] u_diff;
    logic signed [YBC_DIFF_W-1:0] v_diff;
    ybc_prod_t                    prod_reg;
    ybc_prod_t                    prod_next;

    assign u_diff = $signed({1'b0, chroma_blue}) - $signed({1'b0, cfg.chroma_offset});
    assign v_diff = $signed({1'b0, chroma_red}) - $signed({1'b0, cfg.chroma_offset});

    always_comb
    begin
        prod_next.v_red   = $signed({1'b0, cfg.v_to_red})   * v_diff;
        prod_next.u_green = $signed({1'b0, cfg.u_to_green}) * u_diff;
        prod_next.v_green = $signed({1'b0, cfg.v_to_green}) * v_diff;
        prod_next.u_blue  = $signed({1'b0, cfg.u_to_blue})  * u_diff;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

@@ rtl/core/ybc_lane.sv @@
// One pixel lane: adds or subtracts the chroma terms on luma, floors and clamps to 0..255.
module ybc_lane
    import ybc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = YBC_COEF_FRAC_BITS
)
(
    input  logic [YBC_BYTE_W-1:0] luma,
    input  ybc_prod_t             prod,
    output ybc_pixel_t            pixel
);

    localparam int BASE_W = YBC_BYTE_W + 1 + COEF_FRAC_BITS;
    localparam int ACC_W  = ((BASE_W > YBC_PROD_W) ? BASE_W : YBC_PROD_W) + 2;

    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] acc_blue;
    logic signed [ACC_W-1:0] acc_green;
    logic signed [ACC_W-1:0] acc_red;

    function automatic logic [YBC_BYTE_W-1:0] clamp(input logic signed [ACC_W-1:0] acc);
        logic [YBC_BYTE_W-1:0] res;
        if (acc[ACC_W-1])
        begin
            res = '0;
        end
        else if (|acc[ACC_W-2:COEF_FRAC_BITS+YBC_BYTE_W])
        begin
            res = '1;
        end
        else
        begin
            res = acc[COEF_FRAC_BITS+YBC_BYTE_W-1:COEF_FRAC_BITS];
        end
        return res;
    endfunction

    assign base      = ACC_W'($signed({1'b0, luma, {COEF_FRAC_BITS{1'b0}}}));
    assign acc_blue  = base + ACC_W'($signed(prod.u_blue));
    assign acc_green = base - ACC_W'($signed(prod.u_green)) - ACC_W'($signed(prod.v_green));
    assign acc_red   = base + ACC_W'($signed(prod.v_red));

    always_comb
    begin
        pixel.blue  = clamp(acc_blue);
        pixel.green = clamp(acc_green);
        pixel.red   = clamp(acc_red);
    end

endmodule

@@ rtl/core/yuyv_to_bgr_converter_unit.sv @@
// YUYV to BGR converter: top level, config registers, pipeline control and merge stage.
// Converts one packed 4:2:2 word to two BGR pixels per clock, accepting one word
// every cycle while out_ready is high. An accepted word goes first into the stage
// for the shared chroma products, then both pixel lanes in parallel feed the output
// register. A stalled output holds up to two words in flight. The user must write
// gains and offset only while idle; the block itself does not enforce this.
module yuyv_to_bgr_converter_unit
    import ybc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = YBC_COEF_FRAC_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [YBC_CFG_IDX_W-1:0]  cfg_index,
    input  logic [YBC_CFG_DATA_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [YBC_BYTE_W-1:0]     luma_first,
    input  logic [YBC_BYTE_W-1:0]     chroma_blue,
    input  logic [YBC_BYTE_W-1:0]     luma_second,
    input  logic [YBC_BYTE_W-1:0]     chroma_red,
    input  logic                      last_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [YBC_BYTE_W-1:0]     blue_first,
    output logic [YBC_BYTE_W-1:0]     green_first,
    output logic [YBC_BYTE_W-1:0]     red_first,
    output logic [YBC_BYTE_W-1:0]     blue_second,
    output logic [YBC_BYTE_W-1:0]     green_second,
    output logic [YBC_BYTE_W-1:0]     red_second,
    output logic                      last_out
);

    ybc_cfg_t              cfg_reg;
    ybc_cfg_t              cfg_next;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [YBC_BYTE_W-1:0] s1_luma_first_reg;
    logic [YBC_BYTE_W-1:0] s1_luma_second_reg;
    logic                  s1_last_reg;
    logic                  s1_load;
    logic                  s1_advance;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_load;
    ybc_pixel_t            out_first_reg;
    ybc_pixel_t            out_second_reg;
    logic                  out_last_reg;

    ybc_prod_t             prod;
    ybc_pixel_t            lane_first;
    ybc_pixel_t            lane_second;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_V_TO_RED:    cfg_next.v_to_red      = cfg_data[YBC_GAIN_W-1:0];
                CFG_U_TO_GREEN:  cfg_next.u_to_green    = cfg_data[YBC_GAIN_W-1:0];
                CFG_V_TO_GREEN:  cfg_next.v_to_green    = cfg_data[YBC_GAIN_W-1:0];
                CFG_U_TO_BLUE:   cfg_next.u_to_blue     = cfg_data[YBC_GAIN_W-1:0];
                CFG_CHROMA_OFFS: cfg_next.chroma_offset = cfg_data[YBC_BYTE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.v_to_red      <= RST_V_TO_RED;
            cfg_reg.u_to_green    <= RST_U_TO_GREEN;
            cfg_reg.v_to_green    <= RST_V_TO_GREEN;
            cfg_reg.u_to_blue     <= RST_U_TO_BLUE;
            cfg_reg.chroma_offset <= RST_CHROMA_OFFS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline control: each stage moves on when the next one is free
    assign out_load      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_advance    = !s1_valid_reg || out_load;
    assign in_ready      = s1_advance;
    assign s1_load       = in_valid && s1_advance;
    assign s1_valid_next = s1_advance ? in_valid : s1_valid_reg;
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_luma_first_reg  <= luma_first;
            s1_luma_second_reg <= luma_second;
            s1_last_reg        <= last_in;
        end
    end

    ybc_chroma u_chroma (
        .clk         (clk),
        .load        (s1_load),
        .cfg         (cfg_reg),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .prod        (prod)
    );

    ybc_lane #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_first (
        .luma  (s1_luma_first_reg),
        .prod  (prod),
        .pixel (lane_first)
    );

    ybc_lane #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_second (
        .luma  (s1_luma_second_reg),
        .prod  (prod),
        .pixel (lane_second)
    );

    // merge stage: both lanes and the last flag into one result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_first_reg  <= lane_first;
            out_second_reg <= lane_second;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign blue_first   = out_first_reg.blue;
    assign green_first  = out_first_reg.green;
    assign red_first    = out_first_reg.red;
    assign blue_second  = out_second_reg.blue;
    assign green_second = out_second_reg.green;
    assign red_second   = out_second_reg.red;
    assign last_out     = out_last_reg;

    // back-pressure only when both stages are full and the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled with room in the pipeline");

    // an accepted word always occupies the first stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted word lost before the chroma stage");

    // a word in the first stage with a free output reaches the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_ready) |=> out_valid_reg)
        else $error("word lost between chroma stage and output register");

    // a stalled result stays presented
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_last_reg)))
        else $error("pending result dropped or changed");

endmodule
